// ===== rtl/cti_pkg.sv =====
// Shared types, widths and codes of the calibration table interpolator.
package cti_pkg;

  // Table geometry.
  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  // Field widths.
  localparam int OpW     = 2;
  localparam int TempW   = 20;
  localparam int EmfW    = 28;
  localparam int StatusW = 2;

  // Interpolation arithmetic widths: differences, product and divider.
  localparam int DiffW = EmfW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int DvdW  = ProdW - 1;
  localparam int DvsW  = DiffW;

  // Operation codes.
  localparam logic [OpW-1:0] OpWrite   = 2'd0;
  localparam logic [OpW-1:0] OpForward = 2'd1;
  localparam logic [OpW-1:0] OpInverse = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusRange    = 2'd1;
  localparam logic [StatusW-1:0] StatusNoSegment = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic [IdxW-1:0]         point_index;
    logic signed [TempW-1:0] temperature;
    logic signed [EmfW-1:0]  emf_value;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic signed [EmfW-1:0] result_value;
    logic [StatusW-1:0]     status;
  } out_beat_t;

endpackage

// ===== rtl/cti_divider.sv =====
// Serial restoring divider: one quotient bit per cycle on unsigned magnitudes.
module cti_divider
  import cti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int StepW = $clog2(DvdW);
  localparam logic [StepW-1:0] LastStep = StepW'(DvdW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [DvsW-1:0]  dvs_q, dvs_d;
  logic [DvsW-1:0]  rem_q, rem_d;
  logic [DvsW:0]    rem_sh;
  logic [DvsW:0]    trial;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh = {rem_q, dvd_q[DvdW-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!trial[DvsW]) begin
        rem_d = trial[DvsW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DvsW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      end
      step_d = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== rtl/calibration_table_interpolator_unit.sv =====
// Top level: calibration table, search sequencer, multiplier, divider and result register.
//
// Usage: a beat on the input channel (in_valid_i/in_ready_o, in_data_i) is a
// table write or a query. A write stores one temperature/EMF point and returns
// a zero result with status ok. A forward query maps temperature to EMF, an
// inverse query maps EMF to temperature. Every input beat gives exactly one
// beat on the output channel (out_valid_o/out_ready_i, out_data_o).
// point_count must be written by the user through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block itself does not enforce this. A write or
// an unknown operation goes straight to the result state. A query reads the
// last and first points, then scans one table point per cycle, then forms
// the differences and the product, runs the serial divider and finally adds
// and saturates. Queries that end at a clamp or range check, or at a
// zero-width segment, skip the later steps. The scan uses the single table
// read port, and the divider gives one quotient bit per cycle;
// one item is in work at a time and in_ready_o is low meanwhile.
// Reset clears the sequencer and sets point_count to 2; table contents are
// undefined until written. If the receiver stalls, the finished result waits
// in the output register; the next input beat is still taken, and its result
// waits until the output register is free.
module calibration_table_interpolator_unit
  import cti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_beat_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_beat_t       out_data_o
);

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [EmfW-1:0]  emf;
  } entry_t;

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SLast  = 10'b0000000010,
    SFirst = 10'b0000000100,
    SScan  = 10'b0000001000,
    SDiff  = 10'b0000010000,
    SMul   = 10'b0000100000,
    SDivSt = 10'b0001000000,
    SDiv   = 10'b0010000000,
    SAdd   = 10'b0100000000,
    SDone  = 10'b1000000000
  } state_e;

  localparam logic signed [EmfW+1:0] ResMax = (EmfW+2)'((64'sd1 <<< (EmfW - 1)) - 1);
  localparam logic signed [EmfW+1:0] ResMin = (EmfW+2)'(-(64'sd1 <<< (EmfW - 1)));
  localparam int SumW = DvdW + 2;

  // Sign-extends a temperature to the common point width.
  function automatic logic signed [EmfW-1:0] ext_temp(input logic signed [TempW-1:0] t);
    ext_temp = {{(EmfW - TempW){t[TempW-1]}}, t};
  endfunction

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q;
  logic [IdxW-1:0]         last_idx;
  logic [IdxW-1:0]         rd_addr;
  entry_t                  table_q [MaxPoints];
  entry_t                  rd_q;
  logic                    in_fire;
  logic                    inv_q, inv_d;
  logic signed [EmfW-1:0]  qry_q, qry_d;
  logic [IdxW-1:0]         k_q, k_d;
  entry_t                  prev_q, prev_d;
  entry_t                  last_q, last_d;
  logic signed [EmfW-1:0]  x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic signed [DiffW-1:0] dx_q, dx_d, dy_q, dy_d, dq_q, dq_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                    neg_q, neg_d;
  out_beat_t               res_q, res_d;
  out_beat_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;
  logic                    div_start;
  logic [DvdW-1:0]         div_dvd;
  logic [DvsW-1:0]         div_dvs;
  logic                    div_done;
  logic [DvdW-1:0]         div_quo;
  logic [ProdW-1:0]        prod_abs;
  logic [DiffW-1:0]        dx_abs;
  logic signed [SumW-1:0]  sum;
  logic signed [EmfW-1:0]  cur_x, cur_y, prv_x, prv_y, last_x, last_y;
  logic                    last_seg;

  // Effective index of the last point in use, from the clamped point count.
  always_comb begin
    priority if (cnt_q < CntW'(2)) begin
      last_idx = IdxW'(1);
    end else if (cnt_q > CntW'(MaxPoints)) begin
      last_idx = IdxW'(MaxPoints - 1);
    end else begin
      last_idx = IdxW'(cnt_q - CntW'(1));
    end
  end

  // Point count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(2);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (state_q == SIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // Table read address for the next cycle.
  always_comb begin
    unique case (state_q)
      SIdle:   rd_addr = last_idx;
      SLast:   rd_addr = '0;
      SFirst:  rd_addr = IdxW'(1);
      SScan:   rd_addr = k_q + IdxW'(1);
      default: rd_addr = '0;
    endcase
  end

  // Calibration table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_data_i.operation == OpWrite)) begin
      table_q[in_data_i.point_index] <= '{temp: in_data_i.temperature,
                                          emf: in_data_i.emf_value};
    end
    rd_q <= table_q[rd_addr];
  end

  // Axis view of points: forward uses temperature as x, inverse uses EMF.
  always_comb begin
    cur_x    = inv_q ? rd_q.emf : ext_temp(rd_q.temp);
    cur_y    = inv_q ? ext_temp(rd_q.temp) : rd_q.emf;
    prv_x    = inv_q ? prev_q.emf : ext_temp(prev_q.temp);
    prv_y    = inv_q ? ext_temp(prev_q.temp) : prev_q.emf;
    last_x   = inv_q ? last_q.emf : ext_temp(last_q.temp);
    last_y   = inv_q ? ext_temp(last_q.temp) : last_q.emf;
    last_seg = (k_q == last_idx);
  end

  // Magnitudes for the divider and the final signed accumulate.
  always_comb begin
    prod_abs = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
    dx_abs   = dx_q[DiffW-1] ? DiffW'(-dx_q) : DiffW'(dx_q);
    div_dvd  = prod_abs[DvdW-1:0];
    div_dvs  = dx_abs;
    if (neg_q) begin
      sum = SumW'(y0_q) - SumW'({2'b00, div_quo});
    end else begin
      sum = SumW'(y0_q) + SumW'({2'b00, div_quo});
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    inv_d     = inv_q;
    qry_d     = qry_q;
    k_d       = k_q;
    prev_d    = prev_q;
    last_d    = last_q;
    x0_d      = x0_q;
    y0_d      = y0_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    dq_d      = dq_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    res_d     = res_q;
    div_start = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          res_d = '{result_value: '0, status: StatusOk};
          if (in_data_i.operation == OpForward) begin
            inv_d   = 1'b0;
            qry_d   = ext_temp(in_data_i.temperature);
            state_d = SLast;
          end else if (in_data_i.operation == OpInverse) begin
            inv_d   = 1'b1;
            qry_d   = in_data_i.emf_value;
            state_d = SLast;
          end else begin
            state_d = SDone;
          end
        end
      end
      SLast: begin
        last_d  = rd_q;
        state_d = SFirst;
      end
      SFirst: begin
        // End-point checks: range error going forward, clamping going back.
        prev_d = rd_q;
        k_d    = IdxW'(1);
        if (!inv_q) begin
          if ((qry_q < cur_x) || (qry_q > last_x)) begin
            res_d   = '{result_value: '0, status: StatusRange};
            state_d = SDone;
          end else begin
            state_d = SScan;
          end
        end else if (qry_q <= cur_x) begin
          res_d   = '{result_value: cur_y, status: StatusOk};
          state_d = SDone;
        end else if (qry_q >= last_x) begin
          res_d   = '{result_value: last_y, status: StatusOk};
          state_d = SDone;
        end else begin
          state_d = SScan;
        end
      end
      SScan: begin
        // One segment per cycle, from the previous point to the one just read.
        if (!inv_q && ((qry_q < cur_x) || last_seg)) begin
          x0_d = prv_x; y0_d = prv_y; x1_d = cur_x; y1_d = cur_y;
          state_d = SDiff;
        end else if (inv_q && (qry_q >= prv_x) && (qry_q <= cur_x)) begin
          x0_d = prv_x; y0_d = prv_y; x1_d = cur_x; y1_d = cur_y;
          state_d = SDiff;
        end else if (inv_q && (qry_q >= cur_x) && (qry_q <= prv_x)) begin
          x0_d = cur_x; y0_d = cur_y; x1_d = prv_x; y1_d = prv_y;
          state_d = SDiff;
        end else if (last_seg) begin
          res_d   = '{result_value: '0, status: StatusNoSegment};
          state_d = SDone;
        end else begin
          prev_d = rd_q;
          k_d    = k_q + IdxW'(1);
        end
      end
      SDiff: begin
        dx_d    = DiffW'(x1_q) - DiffW'(x0_q);
        dy_d    = DiffW'(y1_q) - DiffW'(y0_q);
        dq_d    = DiffW'(qry_q) - DiffW'(x0_q);
        state_d = SMul;
      end
      SMul: begin
        // A zero-width segment answers with its base point.
        if (dx_q == '0) begin
          res_d   = '{result_value: y0_q, status: StatusOk};
          state_d = SDone;
        end else begin
          prod_d  = ProdW'(dy_q) * ProdW'(dq_q);
          state_d = SDivSt;
        end
      end
      SDivSt: begin
        neg_d     = prod_q[ProdW-1] ^ dx_q[DiffW-1];
        div_start = 1'b1;
        state_d   = SDiv;
      end
      SDiv: begin
        if (div_done) begin
          state_d = SAdd;
        end
      end
      SAdd: begin
        // Saturate to the result range.
        priority if (sum > SumW'(ResMax)) begin
          res_d.result_value = ResMax[EmfW-1:0];
        end else if (sum < SumW'(ResMin)) begin
          res_d.result_value = ResMin[EmfW-1:0];
        end else begin
          res_d.result_value = sum[EmfW-1:0];
        end
        res_d.status = StatusOk;
        state_d      = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Output register: loaded when the result is done and the slot is free.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == SDone) && (!out_valid_q || out_ready_i)) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    inv_q  <= inv_d;
    qry_q  <= qry_d;
    k_q    <= k_d;
    prev_q <= prev_d;
    last_q <= last_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dq_q   <= dq_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  cti_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/tb_calibration_table_interpolator_unit.sv =====
// Testbench for the calibration table interpolator: directed plan, random curves and queries.
module tb_calibration_table_interpolator_unit;
  import cti_pkg::*;

  localparam int ItemTarget    = 1000;
  localparam int CalmAfter     = 900;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 150;
  localparam int WatchdogLimit = 4000;

  localparam logic [OpW-1:0] OpUnused = 2'd3;

  localparam longint EmfMax = 134217727;
  localparam longint EmfMin = -134217728;

  typedef enum {CurveRising, CurveFalling, CurveScattered, CurveUnsorted} curve_shape_e;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } plan_row_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  in_beat_t        in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_beat_t       out_data_o;

  // Local copy of the calibration table and the point count.
  logic signed [TempW-1:0] temp_points [MaxPoints];
  logic signed [EmfW-1:0]  emf_points  [MaxPoints];
  logic [CntW-1:0]         model_point_count = CntW'(2);

  out_beat_t expected_conversions [$];
  plan_row_t directed_plan [$];
  int        preset_counts [$] = '{64, 0, 127, 3, 1, 65, 2};

  int fail_count    = 0;
  int items_sent    = 0;
  int idle_cycles   = 0;
  bit calm          = 1'b0;
  bit hold_request  = 1'b0;

  calibration_table_interpolator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The register value as the block uses it, clamped to the table size.
  function automatic int active_points();
    if (model_point_count < 2) return 2;
    if (model_point_count > MaxPoints) return MaxPoints;
    return int'(model_point_count);
  endfunction

  function automatic longint clamp_result(longint v);
    if (v > EmfMax) return EmfMax;
    if (v < EmfMin) return EmfMin;
    return v;
  endfunction

  // Works out the result beat of one input beat and applies table writes.
  function automatic out_beat_t convert_item(in_beat_t b);
    out_beat_t r;
    int        n, seg, i;
    longint    q, x0, x1, y0, y1, v;
    bit        hit;
    r = '0;
    n = active_points();
    v = 0;
    case (b.operation)
      OpWrite: begin
        temp_points[b.point_index] = b.temperature;
        emf_points[b.point_index]  = b.emf_value;
      end
      OpForward: begin
        q = longint'(b.temperature);
        if (q < temp_points[0] || q > temp_points[n-1]) begin
          r.status = StatusRange;
        end else begin
          // First segment whose upper temperature lies above the query, else the last one.
          seg = n - 2;
          for (i = n - 2; i >= 0; i--) begin
            if (q < temp_points[i+1]) seg = i;
          end
          x0 = longint'(temp_points[seg]);
          x1 = longint'(temp_points[seg+1]);
          y0 = longint'(emf_points[seg]);
          y1 = longint'(emf_points[seg+1]);
          if (x1 == x0) v = y0;
          else v = clamp_result(y0 + ((y1 - y0) * (q - x0)) / (x1 - x0));
          r.result_value = v[EmfW-1:0];
        end
      end
      OpInverse: begin
        q = longint'(b.emf_value);
        if (q <= emf_points[0]) begin
          r.result_value = EmfW'(temp_points[0]);
        end else if (q >= emf_points[n-1]) begin
          r.result_value = EmfW'(temp_points[n-1]);
        end else begin
          // First rising or falling segment that holds the EMF.
          hit = 1'b0;
          for (i = 0; i < n - 1 && !hit; i++) begin
            y0 = longint'(emf_points[i]);
            y1 = longint'(emf_points[i+1]);
            x0 = longint'(temp_points[i]);
            x1 = longint'(temp_points[i+1]);
            if (q >= y0 && q <= y1) begin
              hit = 1'b1;
              if (y1 == y0) v = x0;
              else v = clamp_result(x0 + ((q - y0) * (x1 - x0)) / (y1 - y0));
            end else if (q >= y1 && q <= y0) begin
              hit = 1'b1;
              v = clamp_result(x1 + ((q - y1) * (x0 - x1)) / (y0 - y1));
            end
          end
          if (hit) r.result_value = v[EmfW-1:0];
          else r.status = StatusNoSegment;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic [OpW-1:0] op, int idx, int t, int e, bit typed,
                                         int val, logic [StatusW-1:0] st);
    plan_row_t row;
    row.beat.operation     = op;
    row.beat.point_index   = idx[IdxW-1:0];
    row.beat.temperature   = t[TempW-1:0];
    row.beat.emf_value     = e[EmfW-1:0];
    row.typed              = typed;
    row.want.result_value  = val[EmfW-1:0];
    row.want.status        = st;
    return row;
  endfunction

  function automatic int pick_between(int a, int b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // A query aimed mostly inside the span of the current curve.
  function automatic in_beat_t make_query();
    in_beat_t b;
    int       n, k, lo, hi;
    n             = active_points();
    b.operation   = $urandom_range(0, 1) ? OpForward : OpInverse;
    b.point_index = IdxW'($urandom);
    b.temperature = TempW'($urandom);
    b.emf_value   = EmfW'($urandom);
    k             = $urandom_range(0, 9);
    if (b.operation == OpForward) begin
      lo = int'(temp_points[0]);
      hi = int'(temp_points[n-1]);
      if (k < 7) b.temperature = TempW'(pick_between(lo, hi));
      else if (k == 7) b.temperature = temp_points[$urandom_range(0, n - 1)];
      else if (k == 8) b.temperature = TempW'($urandom_range(0, 1) ? lo - 1 : hi + 1);
    end else begin
      lo = int'(emf_points[0]);
      hi = int'(emf_points[n-1]);
      if (k < 7) b.emf_value = EmfW'(pick_between(lo, hi));
      else if (k == 7) b.emf_value = emf_points[$urandom_range(0, n - 1)];
      else if (k == 8) b.emf_value = EmfW'($urandom_range(0, 1) ? lo - 1 : hi + 1);
    end
    return b;
  endfunction

  // Offers one beat from a falling edge and returns at the falling edge after acceptance.
  task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
    out_beat_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = convert_item(b);
    expected_conversions.push_back(typed ? want : predicted);
    if (b.operation != OpUnused) items_sent++;
    if (items_sent >= CalmAfter) calm = 1'b1;
    @(negedge clk_i);
  endtask

  // Writes point_count once every outstanding result has come back.
  task automatic set_point_count(int value);
    in_valid_i <= 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[CntW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_point_count = value[CntW-1:0];
  endtask

  // Writes a fresh curve into entries 0 to n-1.
  task automatic load_curve(int n);
    int           tp [MaxPoints];
    int           ep [MaxPoints];
    int           tstep, estep, i;
    curve_shape_e shape;
    in_beat_t     b;
    out_beat_t    none;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: shape = CurveRising;
      6, 7:             shape = CurveFalling;
      8:                shape = CurveScattered;
      default:          shape = CurveUnsorted;
    endcase
    case ($urandom_range(0, 2))
      0: begin
        tstep = 1048575 / (n - 1);
        estep = 268435455 / (n - 1);
      end
      1: begin
        tstep = $urandom_range(1, 200);
        estep = $urandom_range(1, 5000);
      end
      default: begin
        tstep = $urandom_range(0, 2);
        estep = $urandom_range(0, 2);
      end
    endcase
    tp[0] = -524288 + int'($urandom_range(0, 1048575 - tstep * (n - 1)));
    if (shape == CurveFalling) ep[0] = 134217727 - int'($urandom_range(0, 268435455 - estep * (n - 1)));
    else ep[0] = -134217728 + int'($urandom_range(0, 268435455 - estep * (n - 1)));
    for (i = 1; i < n; i++) begin
      tp[i] = tp[i-1] + int'($urandom_range(0, tstep));
      if (shape == CurveFalling) ep[i] = ep[i-1] - int'($urandom_range(0, estep));
      else ep[i] = ep[i-1] + int'($urandom_range(0, estep));
    end
    // Scattered and unsorted curves replace the ordered values with noise.
    for (i = 0; i < n; i++) begin
      if (shape == CurveScattered || shape == CurveUnsorted)
        ep[i] = int'($urandom_range(0, 268435455)) - 134217728;
      if (shape == CurveUnsorted) tp[i] = int'($urandom_range(0, 1048575)) - 524288;
    end
    none = '0;
    for (i = 0; i < n; i++) begin
      b.operation   = OpWrite;
      b.point_index = IdxW'(i);
      b.temperature = TempW'(tp[i]);
      b.emf_value   = EmfW'(ep[i]);
      send_beat(b, 1'b0, none);
    end
  endtask

  // Result side: ready in random bursts, stalls, and one long hold when asked.
  initial begin
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  // Compare every result beat with the oldest outstanding conversion.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_conversions.size() == 0) begin
        $error("result beat with no conversion outstanding: value %0d, status %0d",
               out_data_o.result_value, out_data_o.status);
        fail_count++;
      end else begin
        want = expected_conversions.pop_front();
        if (out_data_o.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 out_data_o.result_value);
          fail_count++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int        phase, queries, k, cnt;
    in_beat_t  b;
    out_beat_t none;
    none = '0;

    // Directed plan, run with the reset point count of two.
    directed_plan.push_back(plan_row(OpWrite, 0, -524288, -134217728, 1, 0, StatusOk));
    directed_plan.push_back(plan_row(OpWrite, 1, 524287, 134217727, 1, 0, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 5, -524288, 0, 1, -134217728, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 0, 524287, -1, 1, 134217727, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 0, 0, 0, 0, 0, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 63, -1, 0, 0, 0, StatusOk));
    directed_plan.push_back(plan_row(OpInverse, 0, 0, -134217728, 1, -524288, StatusOk));
    directed_plan.push_back(plan_row(OpInverse, 0, -1, 134217727, 1, 524287, StatusOk));
    directed_plan.push_back(plan_row(OpInverse, 0, 0, 12345, 0, 0, StatusOk));
    directed_plan.push_back(plan_row(OpUnused, 63, -1, -1, 1, 0, StatusOk));
    directed_plan.push_back(plan_row(OpWrite, 63, 100, -1, 1, 0, StatusOk));
    // A narrow curve so that forward queries can fall outside it.
    directed_plan.push_back(plan_row(OpWrite, 0, -1000, -5000, 1, 0, StatusOk));
    directed_plan.push_back(plan_row(OpWrite, 1, 1000, 5000, 1, 0, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 0, -1001, 0, 1, 0, StatusRange));
    directed_plan.push_back(plan_row(OpForward, 0, 1001, 0, 1, 0, StatusRange));
    directed_plan.push_back(plan_row(OpForward, 0, -524288, 0, 1, 0, StatusRange));
    directed_plan.push_back(plan_row(OpForward, 0, 524287, 0, 1, 0, StatusRange));
    directed_plan.push_back(plan_row(OpForward, 0, -1000, 0, 1, -5000, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 0, 1000, 0, 1, 5000, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 0, -999, 0, 0, 0, StatusOk));
    directed_plan.push_back(plan_row(OpInverse, 0, 0, -5001, 1, -1000, StatusOk));
    directed_plan.push_back(plan_row(OpInverse, 0, 0, 1, 0, 0, StatusOk));
    // A segment of zero width in temperature.
    directed_plan.push_back(plan_row(OpWrite, 1, -1000, 7000, 1, 0, StatusOk));
    directed_plan.push_back(plan_row(OpForward, 0, -1000, 0, 0, 0, StatusOk));
    directed_plan.push_back(plan_row(OpInverse, 0, 0, -4999, 0, 0, StatusOk));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_plan[i])
      send_beat(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);

    // Random phases: new point count, new curve, then a run of queries.
    phase = 0;
    while (items_sent < ItemTarget) begin
      if (phase < preset_counts.size()) cnt = preset_counts[phase];
      else if ($urandom_range(0, 4) == 0) cnt = $urandom_range(0, 127);
      else cnt = $urandom_range(2, 8);
      set_point_count(cnt);
      load_curve(active_points());
      if (!calm && (phase == 2 || $urandom_range(0, 9) == 0)) hold_request = 1'b1;
      queries = (active_points() <= 8) ? 30 : 12;
      repeat (queries) begin
        k = $urandom_range(0, 99);
        b = make_query();
        if (k < 6) b.operation = OpWrite;
        else if (k < 10) b.operation = OpUnused;
        send_beat(b, 1'b0, none);
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_conversions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
